/* rtl/srg_pkg.sv */
// Shared constants, request codes and arithmetic helpers for the
// subtractive random generator. No dependencies.
package srg_pkg;

  // table geometry and generator constants
  localparam int          TableDepth = 55;
  localparam int          AddrW      = $clog2(TableDepth);
  localparam int          WordW      = 30;
  localparam int          PtrW       = 6;
  localparam int          SeedW      = 15;

  localparam logic [WordW-1:0] Modulus   = 30'd1000000000;
  localparam logic [WordW-1:0] SeedBase  = 30'd161803398;
  localparam logic [PtrW-1:0]  TableLen  = 6'd55;
  localparam logic [PtrW-1:0]  FillStride = 6'd21;
  localparam logic [PtrW-1:0]  MixOffset = 6'd31;
  localparam logic [PtrW-1:0]  IdxFirstPtr  = 6'd55;
  localparam logic [PtrW-1:0]  IdxSecondPtr = 6'd56;
  localparam logic [AddrW-1:0] LastAddr  = 6'd54;
  localparam logic [1:0]       LastPass  = 2'd3;

  // request codes
  typedef enum logic [1:0] {
    FuncSeed    = 2'd0,
    FuncNext    = 2'd1,
    FuncRead    = 2'd2,
    FuncRestore = 2'd3
  } func_e;

  // (a - b) mod Modulus for a, b below Modulus
  function automatic logic [WordW-1:0] mod_sub(input logic [WordW-1:0] a,
                                              input logic [WordW-1:0] b);
    logic [WordW:0] diff;
    if (a >= b) begin
      diff = {1'b0, a} - {1'b0, b};
    end else begin
      diff = {1'b0, a} + {1'b0, Modulus} - {1'b0, b};
    end
    return diff[WordW-1:0];
  endfunction

  // step a pointer through 1..55, zero also goes to 1
  function automatic logic [PtrW-1:0] ptr_advance(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] n;
    n = p + 6'd1;
    return (n > TableLen) ? 6'd1 : n;
  endfunction

endpackage

/* rtl/subtractive_random_generator.sv */
// Subtractive lagged generator: 55-word table in a dual-read memory, pointer
// and seed registers, sequencer for seeding, output register. Uses srg_pkg.
// Sequence: a next reads both pointed words in the accept cycle, writes their
// difference back in NextWb and then emits it; a table read goes through
// ReadWb; pointer reads, rejected reads and restores go straight to Emit.
// Seeding makes 55 fill writes, the first in the accept cycle, then 4 x 55
// mixing steps of a read and a write each, then the hand-off to the output
// register. A new request is taken only once the last result has gone to the
// output register; a held output beat stalls the input.
// Reset: table reads as zero through per-entry valid flags, pointers zero,
// seed register 1; no clearing pass.
module subtractive_random_generator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srg_pkg::SeedW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   func_i,
  input  logic [5:0]                   status_index_i,
  input  logic [srg_pkg::WordW-1:0]    status_word_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [srg_pkg::WordW-1:0]    result_value_o,
  output logic                         error_flag_o
);

  typedef enum logic [2:0] {
    Idle, NextWb, ReadWb, Fill, MixRd, MixWr, Emit
  } state_e;

  localparam int AW = srg_pkg::AddrW;
  localparam int WW = srg_pkg::WordW;
  localparam int PW = srg_pkg::PtrW;

  state_e              state_q;
  logic [PW-1:0]       p1_q, p2_q;
  logic [srg_pkg::SeedW-1:0] seed_q;
  logic [WW-1:0]       cur_q, prev_q;
  logic [AW-1:0]       slot_q, step_q;
  logic [AW-1:0]       mix_j_q, mix_o_q;
  logic [1:0]          pass_q;
  logic [AW-1:0]       next_wa_q;
  logic [WW-1:0]       hold_res_q;
  logic                hold_err_q;
  logic                out_valid_q;
  logic [WW-1:0]       out_res_q;
  logic                out_err_q;
  logic                vld_q [srg_pkg::TableDepth];

  // memory and its registered read ports
  logic [WW-1:0]       mem [srg_pkg::TableDepth];
  logic [WW-1:0]       rd_a_q, rd_b_q;
  logic                rd_a_vld_q, rd_b_vld_q;

  logic                accept;
  logic                mem_we;
  logic [AW-1:0]       mem_wa, rd_addr_a, rd_addr_b;
  logic [WW-1:0]       mem_wd;
  logic [WW-1:0]       word_a, word_b, diff_ab;
  logic [WW-1:0]       seed_cur;
  logic [PW-1:0]       adv_a, adv_b;
  logic [PW:0]         slot_sum;
  logic [AW-1:0]       slot_nxt;
  logic                idx_table, restore_ok;
  logic                out_free;
  logic [WW-1:0]       imm_res;
  logic                imm_err;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == Idle);
  assign out_free   = !out_valid_q || out_ready_i;

  // masked read words: never-written entries read as zero
  assign word_a  = rd_a_vld_q ? rd_a_q : '0;
  assign word_b  = rd_b_vld_q ? rd_b_q : '0;
  assign diff_ab = srg_pkg::mod_sub(word_a, word_b);

  assign seed_cur = srg_pkg::SeedBase - {{(WW-srg_pkg::SeedW){1'b0}}, seed_q};
  assign adv_a    = srg_pkg::ptr_advance(p1_q);
  assign adv_b    = srg_pkg::ptr_advance(p2_q);

  // scattered fill slot: (slot + 21) mod 55
  assign slot_sum = {1'b0, slot_q} + {1'b0, srg_pkg::FillStride};
  assign slot_nxt = (slot_sum >= {1'b0, srg_pkg::TableLen})
                    ? AW'(slot_sum - {1'b0, srg_pkg::TableLen}) : AW'(slot_sum);

  assign idx_table  = (status_index_i < srg_pkg::TableLen);
  assign restore_ok = idx_table ? (status_word_i < srg_pkg::Modulus)
                                : (status_word_i <= {{(WW-PW){1'b0}}, srg_pkg::TableLen});

  // immediate result of pointer reads and rejected requests
  always_comb begin
    imm_res = '0;
    imm_err = 1'b0;
    unique case (srg_pkg::func_e'(func_i))
      srg_pkg::FuncRead: begin
        if (!idx_table) begin
          if (status_index_i == srg_pkg::IdxFirstPtr) begin
            imm_res = {{(WW-PW){1'b0}}, p1_q};
          end else if (status_index_i == srg_pkg::IdxSecondPtr) begin
            imm_res = {{(WW-PW){1'b0}}, p2_q};
          end else begin
            imm_err = 1'b1;
          end
        end
      end
      srg_pkg::FuncRestore: begin
        if (!idx_table && status_index_i != srg_pkg::IdxFirstPtr &&
            status_index_i != srg_pkg::IdxSecondPtr) begin
          imm_err = 1'b1;
        end else if (!restore_ok) begin
          imm_err = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = '0;
    mem_wd    = '0;
    rd_addr_a = '0;
    rd_addr_b = '0;
    unique case (state_q)
      Idle: begin
        if (accept) begin
          unique case (srg_pkg::func_e'(func_i))
            srg_pkg::FuncSeed: begin
              mem_we = 1'b1;
              mem_wa = srg_pkg::LastAddr;
              mem_wd = seed_cur;
            end
            srg_pkg::FuncNext: begin
              rd_addr_a = AW'(adv_a - 6'd1);
              rd_addr_b = AW'(adv_b - 6'd1);
            end
            srg_pkg::FuncRead: begin
              if (idx_table) rd_addr_a = AW'(status_index_i);
            end
            srg_pkg::FuncRestore: begin
              if (idx_table && restore_ok) begin
                mem_we = 1'b1;
                mem_wa = AW'(status_index_i);
                mem_wd = status_word_i;
              end
            end
            default: ;
          endcase
        end
      end
      NextWb: begin
        mem_we = 1'b1;
        mem_wa = next_wa_q;
        mem_wd = diff_ab;
      end
      Fill: begin
        mem_we = 1'b1;
        mem_wa = slot_q - AW'(1);
        mem_wd = prev_q;
      end
      MixRd: begin
        rd_addr_a = mix_j_q;
        rd_addr_b = mix_o_q;
      end
      MixWr: begin
        mem_we = 1'b1;
        mem_wa = mix_j_q;
        mem_wd = diff_ab;
      end
      default: ;
    endcase
  end

  // table storage, one write and two registered reads per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_a_q <= mem[rd_addr_a];
    rd_b_q <= mem[rd_addr_b];
  end

  // sequencer, pointers, valid flags and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      p1_q        <= '0;
      p2_q        <= '0;
      seed_q      <= 15'd1;
      cur_q       <= '0;
      prev_q      <= '0;
      slot_q      <= '0;
      step_q      <= '0;
      mix_j_q     <= '0;
      mix_o_q     <= '0;
      pass_q      <= '0;
      next_wa_q   <= '0;
      hold_res_q  <= '0;
      hold_err_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_res_q   <= '0;
      out_err_q   <= 1'b0;
      rd_a_vld_q  <= 1'b0;
      rd_b_vld_q  <= 1'b0;
      for (int k = 0; k < srg_pkg::TableDepth; k++) vld_q[k] <= 1'b0;
    end else begin
      // take config writes at any time
      if (cfg_we_i) seed_q <= cfg_wdata_i;

      rd_a_vld_q <= vld_q[rd_addr_a];
      rd_b_vld_q <= vld_q[rd_addr_b];
      if (mem_we) vld_q[mem_wa] <= 1'b1;

      // drop the output beat once taken, unless a new one replaces it
      if (out_valid_q && out_ready_i && state_q != Emit) out_valid_q <= 1'b0;

      unique case (state_q)
        Idle: begin
          if (accept) begin
            hold_res_q <= imm_res;
            hold_err_q <= imm_err;
            unique case (srg_pkg::func_e'(func_i))
              srg_pkg::FuncSeed: begin
                cur_q   <= seed_cur;
                prev_q  <= 30'd1;
                slot_q  <= AW'(srg_pkg::FillStride);
                step_q  <= AW'(1);
                state_q <= Fill;
              end
              srg_pkg::FuncNext: begin
                p1_q      <= adv_a;
                p2_q      <= adv_b;
                next_wa_q <= AW'(adv_a - 6'd1);
                state_q   <= NextWb;
              end
              srg_pkg::FuncRead: begin
                if (idx_table) begin
                  state_q <= ReadWb;
                end else begin
                  state_q <= Emit;
                end
              end
              srg_pkg::FuncRestore: begin
                if (!imm_err) begin
                  if (status_index_i == srg_pkg::IdxFirstPtr) begin
                    p1_q <= status_word_i[PW-1:0];
                  end else if (status_index_i == srg_pkg::IdxSecondPtr) begin
                    p2_q <= status_word_i[PW-1:0];
                  end
                end
                state_q <= Emit;
              end
              default: ;
            endcase
          end
        end
        NextWb: begin
          hold_res_q <= diff_ab;
          state_q    <= Emit;
        end
        ReadWb: begin
          hold_res_q <= word_a;
          state_q    <= Emit;
        end
        Fill: begin
          // advance the two-term recurrence over the scattered slots
          prev_q <= srg_pkg::mod_sub(cur_q, prev_q);
          cur_q  <= prev_q;
          slot_q <= slot_nxt;
          step_q <= step_q + AW'(1);
          if (step_q == srg_pkg::LastAddr) begin
            mix_j_q <= '0;
            mix_o_q <= AW'(srg_pkg::MixOffset);
            pass_q  <= '0;
            state_q <= MixRd;
          end
        end
        MixRd: begin
          state_q <= MixWr;
        end
        MixWr: begin
          mix_j_q <= (mix_j_q == srg_pkg::LastAddr) ? '0 : mix_j_q + AW'(1);
          mix_o_q <= (mix_o_q == srg_pkg::LastAddr) ? '0 : mix_o_q + AW'(1);
          if (mix_j_q == srg_pkg::LastAddr) pass_q <= pass_q + 2'd1;
          if (mix_j_q == srg_pkg::LastAddr && pass_q == srg_pkg::LastPass) begin
            p1_q    <= '0;
            p2_q    <= srg_pkg::MixOffset;
            state_q <= Emit;
          end else begin
            state_q <= MixRd;
          end
        end
        Emit: begin
          // hand the result to the output register when it is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_res_q   <= hold_res_q;
            out_err_q   <= hold_err_q;
            state_q     <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign error_flag_o   = out_err_q;

  // checks
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (result_value_o < srg_pkg::Modulus))
    else $error("result beyond modulus");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && error_flag_o) |-> (result_value_o == '0))
    else $error("flagged beat carries a value");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_q <= srg_pkg::TableLen) && (p2_q <= srg_pkg::TableLen))
    else $error("pointer out of range");

  a_seed_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == MixWr && mix_j_q == srg_pkg::LastAddr && pass_q == srg_pkg::LastPass)
    |=> (p1_q == '0 && p2_q == srg_pkg::MixOffset))
    else $error("pointers not set after seeding");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second beat taken while busy");

endmodule
